@@ hw/rtl/dhcp_client_fsm_defines.svh @@
// ----------------------------------------------------------------------------
// dhcp_client_fsm_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DHCP_CLIENT_FSM_DEFINES_SVH
`define DHCP_CLIENT_FSM_DEFINES_SVH
`define DCF_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
`define DCF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`endif

@@ hw/rtl/dcf_pkg.sv @@
// ----------------------------------------------------------------------------
// dcf_pkg
// Event, state, send, outcome, timer and register codes, defaults and structs for the DHCP client controller.
// ----------------------------------------------------------------------------
package dcf_pkg;
  localparam logic [3:0] EV_START = 4'd0, EV_TXDONE = 4'd1, EV_OFFER = 4'd2,
    EV_ACK = 4'd3, EV_NAK = 4'd4, EV_RXTO = 4'd5, EV_ARP = 4'd6, EV_T1 = 4'd7,
    EV_T2 = 4'd8, EV_LEASE = 4'd9;
  localparam logic [4:0] S_INIT = 5'd0, S_SEL_RT = 5'd1, S_SEL_R = 5'd2,
    S_SEL_T = 5'd3, S_REQ_RT = 5'd4, S_REQ_R = 5'd5, S_REQ_T = 5'd6,
    S_REQ_ARP = 5'd7, S_DECL_T = 5'd8, S_BOUND = 5'd9, S_REN_RT = 5'd10,
    S_REN_R = 5'd11, S_REN_T = 5'd12, S_REN2_RT = 5'd13, S_REN2_T = 5'd14,
    S_RENL_RT = 5'd15, S_RENL_T = 5'd16, S_REB_RT = 5'd17, S_REB_R = 5'd18,
    S_REB_T = 5'd19, S_REBL_RT = 5'd20, S_REBL_T = 5'd21;
  localparam logic [2:0] K_NONE = 3'd0, K_DISC = 3'd1, K_SEL = 3'd2,
    K_RENEW = 3'd3, K_REBIND = 3'd4, K_DECL = 3'd5, K_PROBE = 3'd6;
  localparam logic [2:0] O_NONE = 3'd0, O_BOUND = 3'd1, O_FAIL = 3'd2,
    O_IGN = 3'd3, O_ILL = 3'd4;
  localparam logic [3:0] T_RESP = 4'd1, T_T1 = 4'd2, T_T2 = 4'd4, T_LEASE = 4'd8;
  localparam logic [1:0] R_MAC = 2'd0, R_XID = 2'd1, R_ARP = 2'd2;
  localparam logic [15:0] SERVER_PORT = 16'd67;
  localparam logic [31:0] XID_RESET = 32'h21324354;
  localparam logic [7:0] ARP_LIMIT_RESET = 8'd3;

  typedef struct packed {
    logic [4:0]  state;
    logic [31:0] xid;
    logic [31:0] addr;
    logic [31:0] srv_ip;
    logic [47:0] srv_mac;
    logic [31:0] lease;
    logic [31:0] renew;
    logic [31:0] rebind;
    logic [7:0]  arp_cnt;
  } ctx_t;

  typedef struct packed {
    logic [4:0]  next_state;
    logic [2:0]  send_kind;
    logic [31:0] send_trans_id;
    logic [31:0] request_addr;
    logic [31:0] server_addr;
    logic [47:0] server_hw_out;
    logic [3:0]  arm_mask;
    logic [3:0]  cancel_mask;
    logic [31:0] lease_out;
    logic [31:0] renew_out;
    logic [31:0] rebind_out;
    logic [2:0]  outcome;
  } res_t;
endpackage

@@ hw/rtl/dcf_step.sv @@
// ----------------------------------------------------------------------------
// dcf_step
// Combinational transition: one event against the held context.
// ----------------------------------------------------------------------------
module dcf_step (
  input  dcf_pkg::ctx_t cur,
  input  logic [47:0]   own_mac,
  input  logic [7:0]    arp_limit,
  input  logic [3:0]    operation,
  input  logic [15:0]   source_port,
  input  logic [47:0]   client_hw,
  input  logic [31:0]   msg_trans_id,
  input  logic [31:0]   your_addr,
  input  logic [31:0]   server_id,
  input  logic [47:0]   sender_hw,
  input  logic [31:0]   lease_in,
  input  logic [31:0]   renew_in,
  input  logic [31:0]   rebind_in,
  input  logic [3:0]    option_flags,
  input  logic          arp_found,
  output dcf_pkg::ctx_t nxt,
  output dcf_pkg::res_t res
);
  import dcf_pkg::*;

  logic        filt;
  logic [31:0] xid_inc;
  logic [8:0]  arp_n;
  logic        rdir;
  logic [4:0]  rnxt;
  logic [3:0]  rcan;
  logic        rok;

  assign xid_inc = cur.xid + 32'd1;
  assign arp_n = {1'b0, cur.arp_cnt} + 9'd1;
  assign filt = (source_port != SERVER_PORT) || (client_hw != own_mac)
             || (msg_trans_id != cur.xid);

  always_comb begin
    rok = 1'b1; rdir = 1'b0; rnxt = S_INIT; rcan = 4'd0;
    unique case (cur.state)
      S_REN_RT:  begin rcan = T_T2 | T_LEASE; rnxt = S_REN_T; end
      S_REN2_RT: begin rcan = T_LEASE; rnxt = S_REN2_T; end
      S_REB_RT:  begin rcan = T_LEASE; rnxt = S_REB_T; end
      S_REQ_RT:  rnxt = S_REQ_T;
      S_RENL_RT: rnxt = S_RENL_T;
      S_REBL_RT: rnxt = S_REBL_T;
      S_REN_R:   begin rcan = T_T2 | T_LEASE | T_RESP; rdir = 1'b1; end
      S_REB_R:   begin rcan = T_LEASE | T_RESP; rdir = 1'b1; end
      S_REQ_R:   begin rcan = T_RESP; rdir = 1'b1; end
      default:   rok = 1'b0;
    endcase
  end

  always_comb begin
    nxt = cur;
    res = '0;
    // reply_done with addr from nxt
    unique case (operation)
      EV_START: begin
        if (cur.state == S_INIT) begin
          nxt.xid = xid_inc; res.send_kind = K_DISC; res.send_trans_id = xid_inc;
          nxt.state = S_SEL_RT;
        end else res.outcome = O_IGN;
      end
      EV_TXDONE: begin
        unique case (cur.state)
          S_SEL_RT, S_REQ_RT, S_REN_RT, S_REB_RT: begin
            res.arm_mask = T_RESP; nxt.state = cur.state + 5'd1;
          end
          S_SEL_T: begin
            res.send_kind = K_SEL; res.send_trans_id = cur.xid;
            res.request_addr = cur.addr; res.server_addr = cur.srv_ip;
            nxt.state = S_REQ_RT;
          end
          S_REN_T, S_REN2_T, S_REB_T, S_RENL_T, S_REBL_T, S_REQ_T: begin
            if (cur.state == S_REN_T) res.cancel_mask = T_T2 | T_LEASE;
            else if (cur.state == S_REN2_T || cur.state == S_REB_T)
              res.cancel_mask = T_LEASE;
            if (cur.addr == '0) begin
              nxt.state = S_INIT; res.outcome = O_FAIL;
            end else begin
              nxt.arp_cnt = 8'd1; res.send_kind = K_PROBE;
              res.request_addr = cur.addr; nxt.state = S_REQ_ARP;
            end
          end
          S_REN2_RT: begin
            nxt.xid = xid_inc; res.send_kind = K_REBIND; res.send_trans_id = xid_inc;
            res.request_addr = cur.addr; nxt.state = S_REB_RT;
          end
          S_DECL_T, S_RENL_RT, S_REBL_RT: begin
            nxt.state = S_INIT; res.outcome = O_FAIL;
          end
          default: res.outcome = O_ILL;
        endcase
      end
      EV_OFFER: begin
        if (filt) res.outcome = O_IGN;
        else if ((cur.state == S_SEL_RT || cur.state == S_SEL_R) && option_flags[3]) begin
          nxt.srv_mac = sender_hw; nxt.addr = your_addr; nxt.srv_ip = server_id;
          if (cur.state == S_SEL_RT) nxt.state = S_SEL_T;
          else begin
            res.cancel_mask = T_RESP; res.send_kind = K_SEL;
            res.send_trans_id = cur.xid; res.request_addr = your_addr;
            res.server_addr = server_id; nxt.state = S_REQ_RT;
          end
        end else res.outcome = O_IGN;
      end
      EV_ACK, EV_NAK: begin
        if (filt || !rok || (operation == EV_ACK && !option_flags[2]))
          res.outcome = O_IGN;
        else begin
          if (operation == EV_ACK) begin
            nxt.addr = your_addr; nxt.lease = lease_in;
            nxt.renew = option_flags[0] ? renew_in : {1'b0, lease_in[31:1]};
            nxt.rebind = option_flags[1] ? rebind_in
              : 32'(({lease_in, 3'b000} - {3'b000, lease_in}) >> 3);
          end else nxt.addr = '0;
          res.cancel_mask = rcan;
          if (!rdir) nxt.state = rnxt;
          else if (nxt.addr == '0) begin
            nxt.state = S_INIT; res.outcome = O_FAIL;
          end else begin
            nxt.arp_cnt = 8'd1; res.send_kind = K_PROBE;
            res.request_addr = nxt.addr; nxt.state = S_REQ_ARP;
          end
        end
      end
      EV_RXTO: begin
        if (cur.state == S_SEL_R || cur.state == S_REQ_R) begin
          nxt.xid = xid_inc; res.send_kind = K_DISC; res.send_trans_id = xid_inc;
          nxt.state = S_SEL_RT;
        end else if (cur.state == S_REN_R) begin
          nxt.xid = xid_inc; res.send_kind = K_RENEW; res.send_trans_id = xid_inc;
          res.request_addr = cur.addr; res.server_addr = cur.srv_ip;
          res.server_hw_out = cur.srv_mac; nxt.state = S_REN_RT;
        end else if (cur.state == S_REB_R) begin
          nxt.xid = xid_inc; res.send_kind = K_REBIND; res.send_trans_id = xid_inc;
          res.request_addr = cur.addr; nxt.state = S_REB_RT;
        end else res.outcome = O_ILL;
      end
      EV_ARP: begin
        if (cur.state != S_REQ_ARP) res.outcome = O_ILL;
        else if (arp_found) begin
          res.send_kind = K_DECL; res.send_trans_id = cur.xid;
          res.request_addr = cur.addr; res.server_addr = cur.srv_ip;
          nxt.state = S_DECL_T;
        end else begin
          nxt.arp_cnt = arp_n[8] ? 8'hFF : arp_n[7:0];
          if (arp_n <= {1'b0, arp_limit}) begin
            res.send_kind = K_PROBE; res.request_addr = cur.addr;
          end else begin
            res.arm_mask = T_T1 | T_T2 | T_LEASE;
            res.lease_out = cur.lease; res.renew_out = cur.renew;
            res.rebind_out = cur.rebind; res.outcome = O_BOUND;
            nxt.state = S_BOUND;
          end
        end
      end
      EV_T1: begin
        if (cur.state == S_BOUND) begin
          nxt.xid = xid_inc; res.send_kind = K_RENEW; res.send_trans_id = xid_inc;
          res.request_addr = cur.addr; res.server_addr = cur.srv_ip;
          res.server_hw_out = cur.srv_mac; nxt.state = S_REN_RT;
        end else res.outcome = O_ILL;
      end
      EV_T2: begin
        if (cur.state == S_REN_R) begin
          res.cancel_mask = T_RESP;
          nxt.xid = xid_inc; res.send_kind = K_REBIND; res.send_trans_id = xid_inc;
          res.request_addr = cur.addr; nxt.state = S_REB_RT;
        end else if (cur.state == S_REN_RT) nxt.state = S_REN2_RT;
        else res.outcome = O_ILL;
      end
      EV_LEASE: begin
        unique case (cur.state)
          S_REN2_RT: nxt.state = S_RENL_RT;
          S_REN2_T:  nxt.state = S_RENL_T;
          S_REB_RT:  nxt.state = S_REBL_RT;
          S_REB_T:   nxt.state = S_REBL_T;
          S_REB_R:   begin res.cancel_mask = T_RESP; nxt.state = S_INIT;
                       res.outcome = O_FAIL; end
          default:   res.outcome = O_ILL;
        endcase
      end
      default: res.outcome = O_ILL;
    endcase
    res.next_state = nxt.state;
  end
endmodule

@@ hw/rtl/dhcp_client_fsm.sv @@
// A result is registered in the output register, or first in the skid stage while the output stalls.
// Throughput: one event per cycle while the skid stage is empty; the context register update sets that.
// The skid stage keeps the input open while one result waits; the input closes while the skid stage is full.
// Reset: state INIT, context cleared, transaction id and ARP limit at defaults.
// ----------------------------------------------------------------------------
// dhcp_client_fsm
// DHCP client controller, one event per beat, one result per event.
// ----------------------------------------------------------------------------
module dhcp_client_fsm (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [15:0] source_port,
  input  logic [47:0] client_hw,
  input  logic [31:0] msg_trans_id,
  input  logic [31:0] your_addr,
  input  logic [31:0] server_id,
  input  logic [47:0] sender_hw,
  input  logic [31:0] lease_in,
  input  logic [31:0] renew_in,
  input  logic [31:0] rebind_in,
  input  logic [3:0]  option_flags,
  input  logic        arp_found,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  next_state,
  output logic [2:0]  send_kind,
  output logic [31:0] send_trans_id,
  output logic [31:0] request_addr,
  output logic [31:0] server_addr,
  output logic [47:0] server_hw_out,
  output logic [3:0]  arm_mask,
  output logic [3:0]  cancel_mask,
  output logic [31:0] lease_out,
  output logic [31:0] renew_out,
  output logic [31:0] rebind_out,
  output logic [2:0]  outcome
);
  import dcf_pkg::*;

  ctx_t        ctx, ctx_next, ctx_load;
  res_t        res_next, obuf, skid;
  logic        skid_valid;
  logic [47:0] own_mac;
  logic [7:0]  arp_limit;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_ready = !skid_valid;
  assign take = in_valid && in_ready;

  dcf_step u_step (
    .cur(ctx), .own_mac(own_mac), .arp_limit(arp_limit), .operation(operation),
    .source_port(source_port), .client_hw(client_hw), .msg_trans_id(msg_trans_id),
    .your_addr(your_addr), .server_id(server_id), .sender_hw(sender_hw),
    .lease_in(lease_in), .renew_in(renew_in), .rebind_in(rebind_in),
    .option_flags(option_flags), .arp_found(arp_found),
    .nxt(ctx_next), .res(res_next)
  );

  always_comb begin
    ctx_load = ctx;
    if (take) ctx_load = ctx_next;
    // a transaction id write loads the live context
    if (cfg_valid && cfg_index == R_XID) ctx_load.xid = cfg_data[31:0];
    if (rst) begin
      ctx_load = '0;
      ctx_load.xid = XID_RESET;
    end
  end

  always_ff @(posedge clk) begin
    ctx <= ctx_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      arp_limit <= ARP_LIMIT_RESET;
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          R_MAC: own_mac <= cfg_data;
          R_ARP: arp_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
      // output register with skid: hold a beat that arrives while output stalls
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          obuf <= skid; out_valid <= 1'b1; skid_valid <= 1'b0;
        end else begin
          obuf <= res_next; out_valid <= take;
        end
      end else if (take) begin
        skid <= res_next; skid_valid <= 1'b1;
      end
    end
  end

  assign next_state = obuf.next_state;
  assign send_kind = obuf.send_kind;
  assign send_trans_id = obuf.send_trans_id;
  assign request_addr = obuf.request_addr;
  assign server_addr = obuf.server_addr;
  assign server_hw_out = obuf.server_hw_out;
  assign arm_mask = obuf.arm_mask;
  assign cancel_mask = obuf.cancel_mask;
  assign lease_out = obuf.lease_out;
  assign renew_out = obuf.renew_out;
  assign rebind_out = obuf.rebind_out;
  assign outcome = obuf.outcome;
endmodule

@@ hw/rtl/dhcp_client_fsm_chk.sv @@
// ----------------------------------------------------------------------------
// dhcp_client_fsm_chk
// Port-level checks on the controller's results.
// ----------------------------------------------------------------------------
`include "dhcp_client_fsm_defines.svh"
module dhcp_client_fsm_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  next_state,
  input logic [2:0]  send_kind,
  input logic [31:0] send_trans_id,
  input logic [2:0]  outcome,
  input logic [31:0] server_addr
);
  import dcf_pkg::*;
  `DCF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(next_state))
  `DCF_ASSERT_IMPL(a_bound, out_valid && outcome == O_BOUND, next_state == S_BOUND)
  `DCF_ASSERT_IMPL(a_fail, out_valid && outcome == O_FAIL, next_state == S_INIT)
  `DCF_ASSERT_IMPL(a_probe, out_valid && send_kind == K_PROBE, send_trans_id == '0 && server_addr == '0)
endmodule

bind dhcp_client_fsm dhcp_client_fsm_chk u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .next_state(next_state), .send_kind(send_kind), .send_trans_id(send_trans_id),
  .outcome(outcome), .server_addr(server_addr)
);
